// File: hdl/mctd_pkg.sv
package mctd_pkg;

  localparam int unsigned DRAW_W   = 32;  // random draw, Q0.32
  localparam int unsigned PROB_W   = 32;  // detrapping probability, Q8.24
  localparam int unsigned RATIO_W  = 48;  // detrapping ratio, Q32.16
  localparam int unsigned COUNT_W  = 16;  // trap counts and step indexes
  localparam int unsigned SIG_W    = 48;  // signal, Q32.16
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = COUNT_W + SIG_W + COUNT_W;

  // Dividend is P*n^2 with eight extra fraction bits
  localparam int unsigned DVD_W = 72;
  localparam int unsigned DIV_CNT_W = 7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DETRAP_PROB    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAP_RATIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FILLED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS      = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic restart;    // reload count, clear draw and step indexes
    logic capture;    // latch draw and trap sum r + n
    logic mul;        // form partial products and P*n
    logic cmp;        // compare, drop one electron on success
    logic prep_sq;    // n*n and divisor
    logic prep_num;   // dividend, clear divider
    logic div_step;   // one restoring divider iteration
    logic emit;       // load the output register
    logic fin;        // result closes the run
  } mctd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic no_steps;   // num_steps is zero
    logic init_empty; // initial_filled is zero
    logic step_end;   // draws in this step reached electrons left
    logic n_zero;     // no electrons left
    logic step_last;  // this step is the last one allowed
    logic div_last;   // divider on its final iteration
    logic out_free;   // output register can take a result
  } mctd_sts_t;

endpackage

// File: hdl/monte_carlo_trap_depletion.sv
// Channel  Direction  Beat contents (lowest bits first)
// s_axis   in         tdata: random_draw[31:0]; tuser: restart
// m_axis   out        tdata: step_number[15:0], signal_value[63:16],
//                     electrons_remaining[79:64]; tlast: last
// cfg      in         write only: 0 detrap_prob, 1 trap_ratio,
//                     2 initial_filled, 3 num_steps
//
// A draw passes through accept, partial products, compare and step check.
// A draw that closes a time step, and a restart with a zero fill and a nonzero
// step limit, go on to square and divisor, dividend, the restoring divider for
// P*n^2/(r+n) at one quotient bit per iteration, and the output load, which
// waits for a free output register. Any other restart or an ignored draw ends at accept.
// After reset the run is closed until a restart beat; registers hold
// P = 0, r = 0, initial_filled = 0, num_steps = 1.
// The result sits in an output register; draws keep flowing while it waits,
// and back-pressure only stalls the block when a second result is ready before the
// first has been taken.
module monte_carlo_trap_depletion import mctd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DRAW_W-1:0]     s_axis_tdata,   // random_draw
  input  logic                  s_axis_tuser,   // restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // step_number, signal_value, electrons_remaining
  output logic                  m_axis_tlast    // last
);

  mctd_cmd_t cmd;
  mctd_sts_t sts;

  // Sequence each beat: draw test, step close, divider, result hand-off
  mctd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Hold registers, counters, multipliers, divider and output register
  mctd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .draw_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: hdl/mctd_dp.sv
module mctd_dp import mctd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [DRAW_W-1:0]     draw_i,
  input  mctd_cmd_t             cmd_i,
  output mctd_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam int unsigned SUM_W = RATIO_W + 1;
  localparam int unsigned PHI_W = DRAW_W + SUM_W - 32;
  localparam int unsigned PROD_W = DRAW_W + SUM_W;
  localparam int unsigned PN_W = PROB_W + COUNT_W;
  localparam int unsigned RHS_W = PN_W + 24;
  localparam int unsigned REM_W = SUM_W;

  logic [PROB_W-1:0]   prob_q;
  logic [RATIO_W-1:0]  ratio_q;
  logic [COUNT_W-1:0]  init_q;
  logic [COUNT_W-1:0]  nsteps_q;

  logic [COUNT_W-1:0]  n_q, n_d;
  logic [COUNT_W-1:0]  draw_idx_q, draw_idx_d;
  logic [COUNT_W-1:0]  step_q, step_d;

  logic [DRAW_W-1:0]   draw_q;
  logic [SUM_W-1:0]    sum_q;
  logic [63:0]         pp_lo_q;
  logic [PHI_W-1:0]    pp_hi_q;
  logic [PN_W-1:0]     pn_q;

  logic [31:0]         nn_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [SUM_W-1:0]    den_q;
  logic [REM_W-1:0]    rem_q;
  logic [SUM_W-1:0]    quo_q;
  logic                sat_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic                out_valid_q;
  logic [COUNT_W-1:0]  out_step_q;
  logic [SIG_W-1:0]    out_sig_q;
  logic [COUNT_W-1:0]  out_n_q;
  logic                out_last_q;

  logic [SUM_W-1:0]    trap_sum;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rhs;
  logic                hit;
  logic [REM_W:0]      rem_sh;
  logic                ge;
  logic [SUM_W-1:0]    quo_nx;
  logic [SIG_W-1:0]    signal;

  assign trap_sum = {1'b0, ratio_q} + {{(SUM_W-COUNT_W-16){1'b0}}, n_q, 16'd0};
  assign prod = {pp_hi_q, 32'd0} + {{(PROD_W-64){1'b0}}, pp_lo_q};
  assign rhs  = {{(PROD_W-RHS_W){1'b0}}, pn_q, 24'd0};
  assign hit  = prod < rhs;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign quo_nx = {quo_q[SUM_W-2:0], ge};

  assign signal = (n_q == '0) ? '0 : (sat_q ? '1 : quo_q[SIG_W-1:0]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_q   <= '0;
      ratio_q  <= '0;
      init_q   <= '0;
      nsteps_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DETRAP_PROB:    prob_q   <= cfg_wdata_i[PROB_W-1:0];
        CFG_TRAP_RATIO:     ratio_q  <= cfg_wdata_i[RATIO_W-1:0];
        CFG_INITIAL_FILLED: init_q   <= cfg_wdata_i[COUNT_W-1:0];
        CFG_NUM_STEPS:      nsteps_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Run counters
  always_comb begin
    n_d        = n_q;
    draw_idx_d = draw_idx_q;
    step_d     = step_q;
    if (cmd_i.restart) begin
      n_d        = init_q;
      draw_idx_d = '0;
      step_d     = '0;
    end else if (cmd_i.cmp) begin
      n_d        = n_q - {{(COUNT_W-1){1'b0}}, hit};
      draw_idx_d = draw_idx_q + COUNT_W'(1);
    end else if (cmd_i.emit) begin
      draw_idx_d = '0;
      if (!cmd_i.fin) begin
        step_d = step_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= '0;
      draw_idx_q <= '0;
      step_q     <= '0;
    end else begin
      n_q        <= n_d;
      draw_idx_q <= draw_idx_d;
      step_q     <= step_d;
    end
  end

  // Draw test and divider, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      draw_q <= draw_i;
      sum_q  <= trap_sum;
    end
    if (cmd_i.mul) begin
      pp_lo_q <= {32'd0, draw_q} * {32'd0, sum_q[31:0]};
      pp_hi_q <= {{(PHI_W-DRAW_W){1'b0}}, draw_q} *
                 {{(PHI_W-(SUM_W-32)){1'b0}}, sum_q[SUM_W-1:32]};
      pn_q    <= {{(PN_W-PROB_W){1'b0}}, prob_q} * {{(PN_W-COUNT_W){1'b0}}, n_q};
    end
    if (cmd_i.prep_sq) begin
      nn_q  <= {16'd0, n_q} * {16'd0, n_q};
      den_q <= trap_sum;
    end
    if (cmd_i.prep_num) begin
      dvd_q <= {({32'd0, prob_q} * {32'd0, nn_q}), 8'd0};
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
      cnt_q <= DIV_CNT_W'(DVD_W - 1);
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= ge ? REM_W'(rem_sh - {1'b0, den_q}) : rem_sh[REM_W-1:0];
      quo_q <= quo_nx;
      sat_q <= sat_q | quo_nx[SUM_W-1];
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_step_q <= step_q;
      out_sig_q  <= signal;
      out_n_q    <= n_q;
      out_last_q <= cmd_i.fin;
    end
  end

  assign sts_o.no_steps   = (nsteps_q == '0);
  assign sts_o.init_empty = (init_q == '0);
  assign sts_o.step_end   = (n_q == '0) || (draw_idx_q >= n_q);
  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.step_last  = ({1'b0, step_q} + (COUNT_W+1)'(1)) >= {1'b0, nsteps_q};
  assign sts_o.div_last   = (cnt_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_n_q, out_sig_q, out_step_q};
  assign out_last_o  = out_last_q;

endmodule

// File: hdl/mctd_ctrl.sv
module mctd_ctrl import mctd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_restart_i,
  output logic      in_ready_o,
  input  mctd_sts_t sts_i,
  output mctd_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_END  = 3'd3;
  localparam logic [2:0] ST_SQ   = 3'd4;
  localparam logic [2:0] ST_NUM  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;
  logic       fin_q, fin_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart_i) begin
            cmd_o.restart = 1'b1;
            if (sts_i.no_steps) begin
              done_d = 1'b1;
            end else if (sts_i.init_empty) begin
              // empty run: report step zero at once as last
              done_d  = 1'b1;
              fin_d   = 1'b1;
              state_d = ST_SQ;
            end else begin
              done_d = 1'b0;
            end
          end else if (!done_q) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_END;
      end
      ST_END: begin
        if (sts_i.step_end) begin
          fin_d   = sts_i.n_zero || sts_i.step_last;
          state_d = ST_SQ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SQ: begin
        cmd_o.prep_sq = 1'b1;
        state_d       = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.prep_num = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.fin  = fin_q;
          if (fin_q) begin
            done_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b1;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      fin_q   <= fin_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded over a beat not yet taken");

  a_div_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step && sts_i.div_last) |=> (state_q == ST_EMIT))
    else $error("divider finished without moving to emit");

  a_no_steps_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_restart_i && sts_i.no_steps) |=> (done_q && state_q == ST_IDLE))
    else $error("restart with zero steps left the run open");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.fin) |=> done_q)
    else $error("last result did not close the run");

  a_draw_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !done_q)
    else $error("draw taken on a closed run");

endmodule

// File: bench/trap_depletion_checker.sv
module trap_depletion_checker
  import mctd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [DRAW_W-1:0]     s_axis_tdata_i,   // random_draw
  input  logic                  s_axis_tuser_i,   // restart
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // step_number, signal_value, electrons_remaining
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  m_axis_tlast_i,   // last
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           live_beats_o,
  output int unsigned           results_o,
  output logic                  run_open_o
);

  localparam logic [DVD_W-1:0] SIG_CEIL = {{(DVD_W-SIG_W){1'b0}}, {SIG_W{1'b1}}};

  typedef struct packed {
    logic [COUNT_W-1:0] step;
    logic [SIG_W-1:0]   signal;
    logic [COUNT_W-1:0] remaining;
    logic               last;
  } step_report_t;

  step_report_t step_reports_q[$];

  // Register copies
  logic [PROB_W-1:0]  prob;
  logic [RATIO_W-1:0] ratio;
  logic [COUNT_W-1:0] fill_load;
  logic [COUNT_W-1:0] step_limit;

  // Run state
  logic [COUNT_W-1:0] traps_left;
  logic [COUNT_W-1:0] draws_in_step;
  logic [COUNT_W-1:0] step_idx;
  logic               run_closed;

  int unsigned mismatches;
  int unsigned live_beats;
  int unsigned reports_seen;

  // Luminescence P*n^2/(r+n) in Q32.16, truncated and saturated
  function automatic logic [SIG_W-1:0] glow(input logic [COUNT_W-1:0] n);
    logic [RATIO_W:0]   den;
    logic [63:0]        num;
    logic [DVD_W-1:0]   divisor;
    logic [DVD_W-1:0]   quo;
    if (n == '0) return '0;
    den = {1'b0, ratio} + {17'd0, n, 16'd0};
    num = 64'(prob) * 64'(n) * 64'(n);
    divisor = DVD_W'(den);
    quo = {num, 8'd0} / divisor;
    if (quo > SIG_CEIL) return '1;
    return quo[SIG_W-1:0];
  endfunction

  // draw*(r+n) < P*n with 48 fraction bits on both sides
  function automatic logic detrap_hit(input logic [DRAW_W-1:0] draw,
                                      input logic [COUNT_W-1:0] n);
    logic [RATIO_W:0] sum;
    logic [47:0]      pn;
    logic [80:0]      lhs;
    logic [80:0]      rhs;
    sum = {1'b0, ratio} + {17'd0, n, 16'd0};
    lhs = 81'(sum);
    lhs = lhs * 81'(draw);
    pn  = 48'(prob) * 48'(n);
    rhs = 81'({pn, 24'd0});
    return lhs < rhs;
  endfunction

  task automatic take_beat(input logic [DRAW_W-1:0] draw, input logic restart);
    step_report_t rpt;
    logic         closes_run;
    if (restart) begin
      live_beats++;
      traps_left    = fill_load;
      draws_in_step = '0;
      step_idx      = '0;
      run_closed    = 1'b0;
      if (step_limit == '0) begin
        run_closed = 1'b1;
      end else if (traps_left == '0) begin
        run_closed     = 1'b1;
        rpt.step       = '0;
        rpt.signal     = '0;
        rpt.remaining  = '0;
        rpt.last       = 1'b1;
        step_reports_q.push_back(rpt);
      end
      return;
    end
    if (run_closed) return;
    live_beats++;
    if (detrap_hit(draw, traps_left)) traps_left = traps_left - COUNT_W'(1);
    draws_in_step = draws_in_step + COUNT_W'(1);
    if (traps_left != '0 && draws_in_step < traps_left) return;
    closes_run = (traps_left == '0) ||
                 (({1'b0, step_idx} + 17'd1) >= {1'b0, step_limit});
    rpt.step      = step_idx;
    rpt.signal    = glow(traps_left);
    rpt.remaining = traps_left;
    rpt.last      = closes_run;
    step_reports_q.push_back(rpt);
    draws_in_step = '0;
    if (closes_run) run_closed = 1'b1;
    else step_idx = step_idx + COUNT_W'(1);
  endtask

  task automatic check_report();
    step_report_t got;
    step_report_t want;
    got.step      = m_axis_tdata_i[COUNT_W-1:0];
    got.signal    = m_axis_tdata_i[COUNT_W +: SIG_W];
    got.remaining = m_axis_tdata_i[COUNT_W+SIG_W +: COUNT_W];
    got.last      = m_axis_tlast_i;
    reports_seen++;
    if (step_reports_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result step %0d signal %h remaining %0d last %0b",
                 $realtime, got.step, got.signal, got.remaining, got.last);
      return;
    end
    want = step_reports_q.pop_front();
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch, expected step %0d signal %h remaining %0d last %0b",
                 $realtime, want.step, want.signal, want.remaining, want.last);
        $display("%0t:                  got      step %0d signal %h remaining %0d last %0b",
                 $realtime, got.step, got.signal, got.remaining, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob          = '0;
      ratio         = '0;
      fill_load     = '0;
      step_limit    = COUNT_W'(1);
      traps_left    = '0;
      draws_in_step = '0;
      step_idx      = '0;
      run_closed    = 1'b1;
      mismatches    = 0;
      live_beats    = 0;
      reports_seen  = 0;
      step_reports_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      live_beats_o <= 0;
      results_o    <= 0;
      run_open_o   <= 1'b0;
    end else begin
      // Results leave before the beat of this edge can add one
      if (m_axis_tvalid_i && m_axis_tready_i) check_report();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DETRAP_PROB:    prob       = cfg_wdata_i[PROB_W-1:0];
          CFG_TRAP_RATIO:     ratio      = cfg_wdata_i[RATIO_W-1:0];
          CFG_INITIAL_FILLED: fill_load  = cfg_wdata_i[COUNT_W-1:0];
          CFG_NUM_STEPS:      step_limit = cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) take_beat(s_axis_tdata_i, s_axis_tuser_i);
      fail_count_o <= mismatches;
      pending_o    <= step_reports_q.size();
      live_beats_o <= live_beats;
      results_o    <= reports_seen;
      run_open_o   <= !run_closed;
    end
  end

endmodule

// File: bench/tb_monte_carlo_trap_depletion.sv
module tb_monte_carlo_trap_depletion;
  import mctd_pkg::*;

  // Stop the random part once this many beats have reached the run logic
  localparam int unsigned LIVE_TARGET   = 950;
  // Quiet cycles before a register write: covers a draw still in flight
  localparam int unsigned SETTLE_CYCLES = 100;
  // Longest legal quiet spell is a drain behind the divider and a long stall,
  // followed by the settle wait; allow far more
  localparam int unsigned QUIET_LIMIT   = 2000;
  // Cut long runs short so that many setups fit into the run
  localparam int unsigned RUN_DRAW_CAP  = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [DRAW_W-1:0]     s_tdata   = '0;   // random_draw
  logic                  s_tuser   = 1'b0;  // restart
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // step_number, signal_value, electrons_remaining
  logic                  m_tlast;          // last

  // No idling on either side while this is set
  logic                  burst_mode = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned live_beats;
  int unsigned results;
  logic        run_open;

  int unsigned beats_sent   = 0;
  int unsigned setups       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;

  always #4 clk = ~clk;

  monte_carlo_trap_depletion dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  trap_depletion_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .live_beats_o    (live_beats),
    .results_o       (results),
    .run_open_o      (run_open)
  );

  // Idle spell length: mostly short, now and then long
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_gap();
    if (burst_mode || $urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  // Bias draws towards the ends of the range, where the compare is tight
  function automatic logic [DRAW_W-1:0] pick_draw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DRAW_W'($urandom_range(0, 255));
      3:       return ~DRAW_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Hold the beat until it is taken, then maybe drop valid for a while.
  // Valid is never lowered and raised within one step.
  task automatic send_beat(input logic [DRAW_W-1:0] draw, input logic restart);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= draw;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Drain, then let a draw that gives no result finish inside the block
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Write the registers picked by mask, then release the write enable
  task automatic load_setup(input logic [3:0]         mask,
                            input logic [PROB_W-1:0]  prob,
                            input logic [RATIO_W-1:0] ratio,
                            input logic [COUNT_W-1:0] fill,
                            input logic [COUNT_W-1:0] steps);
    if (mask[CFG_DETRAP_PROB])    write_reg(CFG_DETRAP_PROB, prob);
    if (mask[CFG_TRAP_RATIO])     write_reg(CFG_TRAP_RATIO, ratio);
    if (mask[CFG_INITIAL_FILLED]) write_reg(CFG_INITIAL_FILLED, fill);
    if (mask[CFG_NUM_STEPS])      write_reg(CFG_NUM_STEPS, steps);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a fresh setup. Small trap counts and step limits dominate so that
  // runs stay short; the extremes turn up now and then.
  task automatic randomize_setup();
    logic [3:0]         mask;
    logic [PROB_W-1:0]  prob;
    logic [RATIO_W-1:0] ratio;
    logic [COUNT_W-1:0] fill;
    logic [COUNT_W-1:0] steps;
    for (int i = 0; i < 4; i++) mask[i] = ($urandom_range(0, 9) < 7);
    case ($urandom_range(0, 7))
      0:       prob = '0;
      1:       prob = '1;
      2:       prob = PROB_W'(32'h0100_0000);  // probability one
      default: prob = PROB_W'($urandom_range(0, 32'h0200_0000));
    endcase
    case ($urandom_range(0, 7))
      0:       ratio = '0;
      1:       ratio = '1;
      2:       ratio = {16'($urandom), 32'($urandom)};
      default: ratio = RATIO_W'($urandom_range(0, 32'h0004_0000));
    endcase
    case ($urandom_range(0, 11))
      0:       fill = '0;
      1:       fill = '1;
      2:       fill = COUNT_W'($urandom);
      default: fill = COUNT_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 11))
      0:       steps = '0;
      1:       steps = '1;
      2:       steps = COUNT_W'(1);
      default: steps = COUNT_W'($urandom_range(2, 8));
    endcase
    load_setup(mask, prob, ratio, fill, steps);
  endtask

  // Receiver: random stalls on the result channel, none in burst mode
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (burst_mode) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 65) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= idle_length() - 1;
    end
  end

  // Watchdog: count cycles in which no beat and no write goes through
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("monte_carlo_trap_depletion verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [DRAW_W-1:0] sweep_draws [8];
    int unsigned       drawn;
    int unsigned       roll;

    sweep_draws = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the run is closed: a draw must be dropped. A restart with
    // the reset fill of zero reports step 0 at once and closes the run.
    send_beat('1, 1'b0);
    send_beat('0, 1'b1);
    settle();

    // Zero steps: a restart closes the run at once, and the draw is dropped
    load_setup(4'b1100, '0, '0, COUNT_W'(3), '0);
    send_beat('0, 1'b1);
    send_beat('0, 1'b0);
    settle();

    // P of one half, no ratio: draws either side of the midpoint
    load_setup(4'b1111, PROB_W'(32'h0080_0000), '0, COUNT_W'(4), '1);
    send_beat('0, 1'b1);
    foreach (sweep_draws[i]) send_beat(sweep_draws[i], 1'b0);
    settle();

    // Lower the step limit once the run has closed: these draws are dropped
    load_setup(4'b1000, '0, '0, '0, COUNT_W'(1));
    repeat (4) send_beat('0, 1'b0);
    settle();

    // Extreme P and r: a full draw misses, a zero draw empties the traps
    load_setup(4'b1111, '1, '1, COUNT_W'(1), '1);
    send_beat('0, 1'b1);
    send_beat('1, 1'b0);
    send_beat('0, 1'b0);

    // Two restarts in a row, the second while the run is open
    send_beat('0, 1'b1);
    send_beat('1, 1'b1);
    send_beat('0, 1'b0);

    // Random part: one setup per pass, a restart, then draws until the run
    // closes or hits the draw cap, with the odd restart or mid-run drain thrown in
    while (live_beats < LIVE_TARGET) begin
      settle();
      randomize_setup();
      setups++;
      burst_mode <= ($urandom_range(0, 4) == 0);
      send_beat(pick_draw(), 1'b1);
      drawn = 0;
      do begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_beat(pick_draw(), 1'b1);
        end else if (roll < 5) begin
          // Drain mid-run and move the step limit to a small value, which may fall under the running step
          settle();
          load_setup(4'b1000, '0, '0, '0, COUNT_W'($urandom_range(1, 4)));
        end else begin
          send_beat(pick_draw(), 1'b0);
        end
        drawn++;
      end while (run_open && drawn < RUN_DRAW_CAP);
      // Extra draws after the loop: these should be dropped if the run has closed
      repeat ($urandom_range(0, 2)) send_beat(pick_draw(), 1'b0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats, %0d of them reaching the run logic, over %0d random setups.",
             beats_sent, live_beats, setups);
    $display("Compared %0d step reports; %0d mismatches, %0d still outstanding.",
             results, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("monte_carlo_trap_depletion verification clean");
    end else begin
      $display("monte_carlo_trap_depletion verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mctd_pkg.sv
hdl/mctd_dp.sv
hdl/mctd_ctrl.sv
hdl/monte_carlo_trap_depletion.sv
bench/trap_depletion_checker.sv
bench/tb_monte_carlo_trap_depletion.sv
